@@ hdl/gbpc_pkg.sv @@
package gbpc_pkg;

    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;
    localparam int CNTW         = 7;
    localparam int SPW          = 31;
    localparam int DIV_STEPS    = 49;
    localparam int QW           = 50;

    typedef enum logic [2:0] {
        REG_TABLE_ENABLE  = 3'd0,
        REG_GRID_OFFSET_X = 3'd1,
        REG_GRID_OFFSET_Y = 3'd2,
        REG_GRID_SPACE_X  = 3'd3,
        REG_GRID_SPACE_Y  = 3'd4,
        REG_ROWS_IN_USE   = 3'd5,
        REG_COLS_IN_USE   = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_CORRECTED = 2'd0,
        ST_PASSED    = 2'd1,
        ST_STORED    = 2'd2,
        ST_REJECTED  = 2'd3
    } t_status;

    typedef enum logic {
        OP_CORRECT = 1'b0,
        OP_LOAD    = 1'b1
    } t_op;

    typedef struct packed {
        logic               op;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic        [5:0]  entry_row;
        logic        [5:0]  entry_col;
        logic signed [31:0] entry_x;
        logic signed [31:0] entry_y;
        logic signed [31:0] entry_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic        [1:0]  status;
    } t_out_item;

    typedef struct packed {
        logic                  table_enable;
        logic signed [31:0]    grid_offset_x;
        logic signed [31:0]    grid_offset_y;
        logic        [SPW-1:0] grid_spacing_x;
        logic        [SPW-1:0] grid_spacing_y;
        logic        [CNTW-1:0] rows_in_use;
        logic        [CNTW-1:0] cols_in_use;
    } t_cfg;

    typedef struct packed {
        logic       in_ready;
        logic       capture;
        logic       start_div;
        logic       loc_en;
        logic       rd_issue;
        logic [1:0] rd_idx;
        logic       rd_cap;
        logic [1:0] cap_idx;
        logic       mul_en;
        logic       add_en;
        logic [1:0] ph;
        logic       zadd_en;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic short_path;
        logic div_busy;
        logic out_free;
    } t_sts;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ hdl/gbpc_if.sv @@
interface gbpc_in_if import gbpc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gbpc_out_if import gbpc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hdl/gbpc_div.sv @@
module gbpc_div import gbpc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [32:0]    i_dividend,
    input  logic        [SPW-1:0] i_divisor,
    output logic                  o_busy,
    output logic signed [QW-1:0]  o_quot
);

    localparam int MW = DIV_STEPS;

    logic              r_busy;
    logic [5:0]        r_cnt;
    logic [MW-1:0]     r_mag;
    logic [MW-1:0]     r_q;
    logic [SPW-1:0]    r_rem;
    logic [SPW-1:0]    r_sp;
    logic              r_neg;
    logic [32:0]       abs_d;
    logic [SPW:0]      trial;
    logic [QW-1:0]     qe;

    assign abs_d = i_dividend[32] ? 33'(-i_dividend) : 33'(i_dividend);
    assign trial = {r_rem, r_mag[MW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'(DIV_STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= {abs_d, 16'b0};
            r_q   <= '0;
            r_rem <= '0;
            r_neg <= i_dividend[32];
            r_sp  <= i_divisor;
        end else if (r_busy) begin
            r_mag <= {r_mag[MW-2:0], 1'b0};
            if (trial >= {1'b0, r_sp}) begin
                r_rem <= SPW'(trial - {1'b0, r_sp});
                r_q   <= {r_q[MW-2:0], 1'b1};
            end else begin
                r_rem <= trial[SPW-1:0];
                r_q   <= {r_q[MW-2:0], 1'b0};
            end
        end
    end

    assign qe     = {1'b0, r_q};
    assign o_quot = r_neg ? $signed(~qe + QW'(r_rem == '0)) : $signed(qe);
    assign o_busy = r_busy;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy) else $error("divider did not start");
    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == 6'd1 && !i_start) |=> !r_busy) else $error("divider overran");

endmodule

@@ hdl/gbpc_ctrl.sv @@
module gbpc_ctrl import gbpc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_DIV  = 8'b00000010,
        S_LOC  = 8'b00000100,
        S_RD   = 8'b00001000,
        S_MUL  = 8'b00010000,
        S_ADD  = 8'b00100000,
        S_ZADD = 8'b01000000,
        S_DONE = 8'b10000000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic [1:0] r_ph, n_ph;
    logic [1:0] r_ax, n_ax;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ph    = r_ph;
        n_ax    = r_ax;
        o_cmd   = '0;
        o_cmd.ph = r_ph;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    o_cmd.capture   = 1'b1;
                    o_cmd.start_div = !i_sts.short_path;
                    n_state = i_sts.short_path ? S_DONE : S_DIV;
                end
            end
            S_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = S_LOC;
                end
            end
            S_LOC: begin
                o_cmd.loc_en = 1'b1;
                n_cnt   = '0;
                n_state = S_RD;
            end
            S_RD: begin
                o_cmd.rd_issue = !r_cnt[2];
                o_cmd.rd_idx   = r_cnt[1:0];
                o_cmd.rd_cap   = (r_cnt != 3'd0);
                o_cmd.cap_idx  = r_cnt[1:0] - 2'd1;
                n_cnt = r_cnt + 3'd1;
                if (r_cnt[2]) begin
                    n_ph    = '0;
                    n_ax    = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state = S_ADD;
            end
            S_ADD: begin
                o_cmd.add_en = 1'b1;
                if (r_ph == 2'd2) begin
                    n_ph = '0;
                    if (r_ax == 2'd2) begin
                        n_state = S_ZADD;
                    end else begin
                        n_ax    = r_ax + 2'd1;
                        n_state = S_MUL;
                    end
                end else begin
                    n_ph    = r_ph + 2'd1;
                    n_state = S_MUL;
                end
            end
            S_ZADD: begin
                o_cmd.zadd_en = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ph    <= '0;
            r_ax    <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ph    <= n_ph;
            r_ax    <= n_ax;
        end
    end

    a_div_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_sts.in_valid && !i_sts.short_path) |=> i_sts.div_busy)
        else $error("correct item accepted without division");

endmodule

@@ hdl/gbpc_datapath.sv @@
module gbpc_datapath import gbpc_pkg::*; #(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RIW   = $clog2(MAX_ROWS);
    localparam int CIW   = $clog2(MAX_COLS);
    localparam int REW   = (RIW + 1 > CNTW) ? RIW + 1 : CNTW;
    localparam int CEW   = (CIW + 1 > CNTW) ? CIW + 1 : CNTW;

    logic signed [31:0] mem_x [DEPTH];
    logic signed [31:0] mem_y [DEPTH];
    logic signed [31:0] mem_z [DEPTH];

    logic [REW-1:0] rows_eff, lim_r;
    logic [CEW-1:0] cols_eff, lim_c;
    logic           load_ok, wr_en, short_path;
    logic [AW-1:0]  wr_addr, base, rd_addr;

    logic signed [32:0]   dvd_x, dvd_y;
    logic signed [QW-1:0] q_x, q_y;
    logic                 busy_x, busy_y;
    logic signed [33:0]   cell_x, cell_y;
    logic signed [31:0]   frac_x, frac_y;

    logic [CIW-1:0]     r_col;
    logic [RIW-1:0]     r_row;
    logic signed [31:0] r_fx, r_fy, r_pz;
    logic signed [31:0] r_mx_q, r_my_q, r_mz_q;
    logic signed [31:0] r_cx [4];
    logic signed [31:0] r_cy [4];
    logic signed [31:0] r_cz [4];
    logic signed [31:0] r_lo, r_hi, r_a;
    logic signed [64:0] r_prod;
    logic signed [31:0] r_rx, r_ry, r_rz;
    logic [1:0]         r_status;
    logic               r_out_valid;
    t_out_item          r_out;

    logic signed [31:0] op_a, op_b, op_f;
    logic signed [32:0] diff;
    logic signed [31:0] blend_res;

    function automatic logic signed [33:0] clamp_cell(input logic signed [QW-1:0] q,
                                                      input logic signed [33:0] lim);
        logic signed [33:0] c;
        c = q[QW-1:16];
        if (c < 34'sd0) begin
            c = '0;
        end else if (c > lim) begin
            c = lim;
        end
        return c;
    endfunction

    always_comb begin
        if (i_cfg.rows_in_use < CNTW'(2)) begin
            rows_eff = REW'(2);
        end else if (REW'(i_cfg.rows_in_use) > REW'(MAX_ROWS)) begin
            rows_eff = REW'(MAX_ROWS);
        end else begin
            rows_eff = REW'(i_cfg.rows_in_use);
        end
        if (i_cfg.cols_in_use < CNTW'(2)) begin
            cols_eff = CEW'(2);
        end else if (CEW'(i_cfg.cols_in_use) > CEW'(MAX_COLS)) begin
            cols_eff = CEW'(MAX_COLS);
        end else begin
            cols_eff = CEW'(i_cfg.cols_in_use);
        end
    end

    assign lim_r = rows_eff - REW'(2);
    assign lim_c = cols_eff - CEW'(2);

    assign load_ok = (REW'(i_in_data.entry_row) < rows_eff) &&
                     (CEW'(i_in_data.entry_col) < cols_eff);
    assign wr_addr = AW'(i_in_data.entry_row) * AW'(MAX_COLS) + AW'(i_in_data.entry_col);
    assign wr_en   = i_cmd.capture && (i_in_data.op == OP_LOAD) && load_ok;

    assign short_path = (i_in_data.op == OP_LOAD) || !i_cfg.table_enable ||
                        (i_cfg.grid_spacing_x == '0) || (i_cfg.grid_spacing_y == '0);

    assign o_sts.in_valid   = i_in_valid;
    assign o_sts.short_path = short_path;
    assign o_sts.div_busy   = busy_x || busy_y;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign dvd_x = 33'(i_in_data.pos_x) - 33'(i_cfg.grid_offset_x);
    assign dvd_y = 33'(i_in_data.pos_y) - 33'(i_cfg.grid_offset_y);

    gbpc_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start_div),
        .i_dividend (dvd_x),
        .i_divisor  (i_cfg.grid_spacing_x),
        .o_busy     (busy_x),
        .o_quot     (q_x)
    );

    gbpc_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start_div),
        .i_dividend (dvd_y),
        .i_divisor  (i_cfg.grid_spacing_y),
        .o_busy     (busy_y),
        .o_quot     (q_y)
    );

    always_comb begin
        cell_x = clamp_cell(q_x, $signed(34'(lim_c)));
        cell_y = clamp_cell(q_y, $signed(34'(lim_r)));
        frac_x = sat32(64'(q_x) - (64'(cell_x) <<< 16));
        frac_y = sat32(64'(q_y) - (64'(cell_y) <<< 16));
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_x[wr_addr] <= i_in_data.entry_x;
            mem_y[wr_addr] <= i_in_data.entry_y;
            mem_z[wr_addr] <= i_in_data.entry_z;
        end
        r_mx_q <= mem_x[rd_addr];
        r_my_q <= mem_y[rd_addr];
        r_mz_q <= mem_z[rd_addr];
    end

    assign base = AW'(r_row) * AW'(MAX_COLS) + AW'(r_col);

    always_comb begin
        unique case (i_cmd.rd_idx)
            2'd0: rd_addr = base;
            2'd1: rd_addr = base + AW'(1);
            2'd2: rd_addr = base + AW'(MAX_COLS);
            2'd3: rd_addr = base + AW'(MAX_COLS + 1);
        endcase
    end

    always_comb begin
        unique case (i_cmd.ph)
            2'd1: begin
                op_a = r_cx[2];
                op_b = r_cx[3];
                op_f = r_fx;
            end
            2'd2: begin
                op_a = r_lo;
                op_b = r_hi;
                op_f = r_fy;
            end
            default: begin
                op_a = r_cx[0];
                op_b = r_cx[1];
                op_f = r_fx;
            end
        endcase
        diff      = 33'(op_b) - 33'(op_a);
        blend_res = sat32(64'(r_a) + 64'($signed(r_prod[64:16])));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pz <= i_in_data.pos_z;
            if (i_in_data.op == OP_LOAD) begin
                r_rx     <= '0;
                r_ry     <= '0;
                r_rz     <= '0;
                r_status <= load_ok ? ST_STORED : ST_REJECTED;
            end else if (short_path) begin
                r_rx     <= i_in_data.pos_x;
                r_ry     <= i_in_data.pos_y;
                r_rz     <= i_in_data.pos_z;
                r_status <= ST_PASSED;
            end else begin
                r_status <= ST_CORRECTED;
            end
        end
        if (i_cmd.loc_en) begin
            r_col <= cell_x[CIW-1:0];
            r_row <= cell_y[RIW-1:0];
            r_fx  <= frac_x;
            r_fy  <= frac_y;
        end
        if (i_cmd.rd_cap) begin
            r_cx[i_cmd.cap_idx] <= r_mx_q;
            r_cy[i_cmd.cap_idx] <= r_my_q;
            r_cz[i_cmd.cap_idx] <= r_mz_q;
        end
        if (i_cmd.mul_en) begin
            r_a    <= op_a;
            r_prod <= diff * op_f;
        end
        if (i_cmd.add_en) begin
            unique case (i_cmd.ph)
                2'd0: r_lo <= blend_res;
                2'd1: r_hi <= blend_res;
                default: begin
                    r_rx <= r_ry;
                    r_ry <= r_rz;
                    r_rz <= blend_res;
                    r_cx <= r_cy;
                    r_cy <= r_cz;
                end
            endcase
        end
        if (i_cmd.zadd_en) begin
            r_rz <= sat32(64'(r_rz) + 64'(r_pz));
        end
        if (i_cmd.out_load) begin
            r_out.out_x  <= r_rx;
            r_out.out_y  <= r_ry;
            r_out.out_z  <= r_rz;
            r_out.status <= r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_cell_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.loc_en) |-> (CEW'(r_col) <= lim_c && REW'(r_row) <= lim_r))
        else $error("grid cell outside table");

endmodule

@@ hdl/grid_bilinear_position_correction_core.sv @@
// channel   dir  handshake         payload
// i_in      in   valid/ready       t_in_item: op, position, grid entry
// o_out     out  valid/ready       t_out_item: out_x, out_y, out_z, status
// apb       in   psel/penable      7 registers at 4*i, pready tied high
//
// Correct item: the two 49-step shift-subtract dividers for the cell position,
// then four table reads, nine blends on one multiplier and the Z offset add.
// Load and pass-through items skip the division and blends. One item in flight at a time.
// Reset is synchronous, active low; the table is not cleared.
// The next item is taken while a finished result waits in the output register.
module grid_bilinear_position_correction_core import gbpc_pkg::*; #(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gbpc_in_if.sink     i_in,
    gbpc_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg     r_cfg;
    t_cmd     cmd;
    t_sts     sts;
    t_reg_idx reg_idx;
    logic     wr;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign wr      = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.table_enable   <= 1'b0;
            r_cfg.grid_offset_x  <= '0;
            r_cfg.grid_offset_y  <= '0;
            r_cfg.grid_spacing_x <= SPW'(65536);
            r_cfg.grid_spacing_y <= SPW'(65536);
            r_cfg.rows_in_use    <= CNTW'(2);
            r_cfg.cols_in_use    <= CNTW'(2);
        end else if (wr) begin
            unique case (reg_idx)
                REG_TABLE_ENABLE:  r_cfg.table_enable   <= pwdata[0];
                REG_GRID_OFFSET_X: r_cfg.grid_offset_x  <= pwdata;
                REG_GRID_OFFSET_Y: r_cfg.grid_offset_y  <= pwdata;
                REG_GRID_SPACE_X:  r_cfg.grid_spacing_x <= pwdata[SPW-1:0];
                REG_GRID_SPACE_Y:  r_cfg.grid_spacing_y <= pwdata[SPW-1:0];
                REG_ROWS_IN_USE:   r_cfg.rows_in_use    <= pwdata[CNTW-1:0];
                REG_COLS_IN_USE:   r_cfg.cols_in_use    <= pwdata[CNTW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_TABLE_ENABLE:  prdata = {31'b0, r_cfg.table_enable};
            REG_GRID_OFFSET_X: prdata = r_cfg.grid_offset_x;
            REG_GRID_OFFSET_Y: prdata = r_cfg.grid_offset_y;
            REG_GRID_SPACE_X:  prdata = {1'b0, r_cfg.grid_spacing_x};
            REG_GRID_SPACE_Y:  prdata = {1'b0, r_cfg.grid_spacing_y};
            REG_ROWS_IN_USE:   prdata = {25'b0, r_cfg.rows_in_use};
            REG_COLS_IN_USE:   prdata = {25'b0, r_cfg.cols_in_use};
            default:           prdata = '0;
        endcase
    end

    assign i_in.ready = cmd.in_ready;

    gbpc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    gbpc_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_valid  (i_in.valid),
        .i_in_data   (i_in.data),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_data  (o_out.data)
    );

endmodule
